// ===== rtl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8d_pkg;

  // Byte classes and masks used by the decoder.
  localparam logic [7:0]  ASCII_MAX   = 8'h7F;
  localparam logic [7:0]  LEAD2_MIN   = 8'hC0;
  localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
  localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
  localparam logic [7:0]  CONT_MASK   = 8'h3F;
  localparam logic [7:0]  LEAD2_MASK  = 8'h1F;
  localparam logic [7:0]  LEAD3_MASK  = 8'h0F;
  localparam logic [7:0]  LEAD4_MASK  = 8'h07;
  localparam logic [20:0] QMARK       = 21'd63;

  // Sequence lengths; zero means no sequence is pending.
  localparam logic [2:0]  LEN_IDLE    = 3'd0;
  localparam logic [2:0]  LEN_TWO     = 3'd2;
  localparam logic [2:0]  LEN_THREE   = 3'd3;
  localparam logic [2:0]  LEN_FOUR    = 3'd4;

  // One decoded result beat.
  typedef struct packed {
    logic [20:0] code_point;
    logic        bad_char;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/utf8_stream_decoder_core.sv =====
// Top level of the UTF-8 stream decoder: byte beats in, code point beats out.
//
//   Channel | Direction | Handshake           | Payload
//   input   | in        | in_valid / in_stall | in_byte, in_last
//   output  | out       | out_valid/out_stall | code_point, bad_char, out_last
//
// One byte is accepted per cycle while in_stall is low; the byte that completes a
// result is decoded combinationally and the result is registered in the output register.
// A two-entry output buffer keeps input flowing while a result is stalled;
// in_stall rises only when both entries hold results.
// Reset is synchronous and clears the pending sequence and the buffer.
`default_nettype none

module utf8_stream_decoder_core
  import u8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [20:0]      code_point,
  output logic             bad_char,
  output logic             out_last
);

  logic accept;
  logic res_valid;
  res_t res;
  res_t out_data;

  assign accept = in_valid && !in_stall;

  // Decode the accepted byte against the pending sequence.
  u8d_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .res_valid (res_valid),
    .res       (res)
  );

  // Buffer results toward the output channel.
  u8d_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign code_point = out_data.code_point;
  assign bad_char   = out_data.bad_char;
  assign out_last   = out_data.last;

endmodule

`default_nettype wire

// ===== rtl/u8d_decode.sv =====
// Sequence state and combinational byte decode for the UTF-8 stream decoder.
`default_nettype none

module u8d_decode
  import u8d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            res_valid,
  output res_t            res
);

  logic [7:0]  lead_byte;
  logic [17:0] payload_bits;
  logic [2:0]  expected_length;
  logic [2:0]  received_count;

  logic [7:0]  lead_byte_next;
  logic [17:0] payload_bits_next;
  logic [2:0]  expected_length_next;
  logic [2:0]  received_count_next;

  logic [17:0] pay_shift;
  logic [2:0]  cnt_inc;
  logic [2:0]  len_eff;
  logic [2:0]  missing;
  logic [20:0] lead_part;
  logic [20:0] pay_wide;
  logic [20:0] pay_part;

  // Continuation path: gather six bits and find how far to shift them.
  always_comb begin
    pay_shift = {payload_bits[11:0], in_byte[5:0]};
    cnt_inc   = received_count + 3'd1;
    case (expected_length)
      LEN_THREE: len_eff = LEN_THREE;
      LEN_FOUR:  len_eff = LEN_FOUR;
      default:   len_eff = LEN_TWO;
    endcase
    missing = (len_eff > cnt_inc) ? (len_eff - cnt_inc) : 3'd0;
    case (len_eff)
      LEN_FOUR:  lead_part = {lead_byte[2:0], 18'd0};
      LEN_THREE: lead_part = {5'd0, lead_byte[3:0], 12'd0};
      default:   lead_part = {10'd0, lead_byte[4:0], 6'd0};
    endcase
    pay_wide = {3'd0, pay_shift};
    case (missing)
      3'd1:    pay_part = {pay_wide[14:0], 6'd0};
      3'd2:    pay_part = {pay_wide[8:0], 12'd0};
      default: pay_part = pay_wide;
    endcase
  end

  // Next state and result for the byte on the input.
  always_comb begin
    lead_byte_next       = lead_byte;
    payload_bits_next    = payload_bits;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    res_valid            = 1'b0;
    res.code_point       = {13'd0, in_byte};
    res.bad_char         = 1'b0;
    res.last             = in_last;
    if (expected_length == LEN_IDLE) begin
      if (in_byte inside {[8'h00:ASCII_MAX]}) begin
        res_valid = 1'b1;
      end else if ((in_byte < LEAD2_MIN) || in_last) begin
        // Stray continuation byte, or a lead with nothing after it.
        res_valid      = 1'b1;
        res.code_point = QMARK;
        res.bad_char   = 1'b1;
      end else begin
        lead_byte_next      = in_byte;
        payload_bits_next   = 18'd0;
        received_count_next = 3'd1;
        if (in_byte >= LEAD4_MIN) begin
          expected_length_next = LEN_FOUR;
        end else if (in_byte >= LEAD3_MIN) begin
          expected_length_next = LEN_THREE;
        end else begin
          expected_length_next = LEN_TWO;
        end
      end
    end else begin
      payload_bits_next   = pay_shift;
      received_count_next = cnt_inc;
      if ((cnt_inc >= expected_length) || in_last) begin
        // Sequence complete, or the string ended early; missing bytes count as zero.
        res_valid            = 1'b1;
        res.code_point       = lead_part | pay_part;
        lead_byte_next       = 8'd0;
        payload_bits_next    = 18'd0;
        expected_length_next = LEN_IDLE;
        received_count_next  = 3'd0;
      end
    end
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte       <= 8'd0;
      payload_bits    <= 18'd0;
      expected_length <= LEN_IDLE;
      received_count  <= 3'd0;
    end else if (accept) begin
      lead_byte       <= lead_byte_next;
      payload_bits    <= payload_bits_next;
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8d_skid.sv =====
// Output register with a skid stage for decoded result beats.
`default_nettype none

module u8d_skid
  import u8d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  res_t      push_data,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_data
);

  logic main_valid;
  logic skid_valid;
  res_t main_data;
  res_t skid_data;
  logic pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload registers; the main register holds while the beat is stalled.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8d_checker.sv =====
// Port-level assertions for the UTF-8 stream decoder, bound to the top level.
`default_nettype none

module u8d_checker
  import u8d_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [20:0] code_point,
  input wire logic        bad_char,
  input wire logic        out_last
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(code_point) && $stable(bad_char) && $stable(out_last))
    else $error("result payload changed while stalled");

  // An error beat always carries the question mark.
  a_bad_qmark: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_char |-> code_point == QMARK)
    else $error("error beat without question mark");

  // Reset empties the output buffer and releases the input.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

  // A stall on input needs a stalled result waiting on output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind utf8_stream_decoder_core u8d_checker u_chk (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the UTF-8 stream decoder core.
`default_nettype none

module testbench;
  import u8d_pkg::*;

  // Receiver stall patterns.
  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  // Shapes of generated sequences.
  localparam int SEQ_ASCII = 0;
  localparam int SEQ_MULTI = 1;
  localparam int SEQ_STRAY = 2;

  localparam int TOTAL_BYTES = 1050;
  localparam int NOISE_BYTES = 180;
  localparam int DRAIN_LIMIT = 50000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [20:0] code_point;
  logic        bad_char;
  logic        out_last;

  // Predictor state for the pending sequence.
  logic [7:0]  lead_q;
  logic [17:0] bits_q;
  logic [2:0]  len_q;
  logic [2:0]  cnt_q;

  res_t expected_cps[$];
  int   errors;
  int   bytes_sent;
  int   cps_checked;
  int   bad_seen;
  int   burst_left;

  utf8_stream_decoder_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_point(code_point),
    .bad_char  (bad_char),
    .out_last  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit in case the block hangs.
  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  // Clear the predicted sequence state.
  task automatic clear_sequence();
    lead_q = '0;
    bits_q = '0;
    len_q  = LEN_IDLE;
    cnt_q  = '0;
  endtask

  // Append one expected result beat to the tail of the queue.
  task automatic queue_expected(input res_t r);
    expected_cps = {expected_cps, r};
  endtask

  // Work out what one accepted byte should produce and queue it.
  task automatic decode_byte(input logic [7:0] b, input logic l);
    res_t        r;
    logic [7:0]  mask;
    int          len;
    int          missing;
    logic [31:0] cp;
    if (len_q == LEN_IDLE) begin
      if (b <= ASCII_MAX) begin
        r.code_point = {13'd0, b};
        r.bad_char   = 1'b0;
        r.last       = l;
        queue_expected(r);
      end else if (b < LEAD2_MIN || l) begin
        r.code_point = QMARK;
        r.bad_char   = 1'b1;
        r.last       = l;
        queue_expected(r);
        clear_sequence();
      end else begin
        lead_q = b;
        bits_q = '0;
        cnt_q  = 3'd1;
        if (b >= LEAD4_MIN) len_q = LEN_FOUR;
        else if (b >= LEAD3_MIN) len_q = LEN_THREE;
        else len_q = LEN_TWO;
      end
    end else begin
      // Continuation bytes are folded in unchecked.
      bits_q = {bits_q[11:0], b[5:0]};
      cnt_q  = cnt_q + 3'd1;
      if (cnt_q >= len_q || l) begin
        case (len_q)
          LEN_FOUR:  mask = LEAD4_MASK;
          LEN_THREE: mask = LEAD3_MASK;
          default:   mask = LEAD2_MASK;
        endcase
        len     = int'(len_q);
        missing = len - int'(cnt_q);
        cp = (32'(lead_q & mask) << (6 * (len - 1))) | (32'(bits_q) << (6 * missing));
        r.code_point = cp[20:0];
        r.bad_char   = 1'b0;
        r.last       = l;
        queue_expected(r);
        clear_sequence();
      end
    end
  endtask

  // Send one byte beat, with an occasional idle gap between bursts.
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_byte  <= 8'($urandom);
        in_last  <= 1'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    decode_byte(b, l);
  endtask

  // Receiver stalls follow their own changing pattern.
  initial begin
    int mode;
    int left;
    out_stall = 1'b0;
    mode = STALL_NONE;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
        left = $urandom_range(10, 150);
      end
      left--;
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) != 0);
        default:     out_stall <= (left % 3 != 0);
      endcase
    end
  end

  // Compare each accepted result beat with the oldest expected code point.
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (bad_char) bad_seen++;
      if (expected_cps.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: code_point=%h bad_char=%b last=%b",
                 $time, code_point, bad_char, out_last);
      end else begin
        want = expected_cps.pop_front();
        cps_checked++;
        if (code_point !== want.code_point) begin
          errors++;
          $display("%0t: code_point expected %h, got %h", $time, want.code_point, code_point);
        end
        if (bad_char !== want.bad_char) begin
          errors++;
          $display("%0t: bad_char expected %b, got %b", $time, want.bad_char, bad_char);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%0t: out_last expected %b, got %b", $time, want.last, out_last);
        end
      end
    end
  end

  // Extremes, each sequence length and each irregular case.
  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // Stray continuation bytes while idle.
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b1);
    // Lone lead bytes at the end of a string.
    send_byte(8'hC0, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Complete two, three and four byte sequences.
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // A lead above 0xF7 still acts as a four byte lead.
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // String ends partway through a sequence.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    // Continuation bytes are not checked.
    send_byte(8'hD5, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Mostly well-formed sequences with random content and string ends.
  task automatic test_random_sequences(input int target);
    int          shape;
    int          n;
    int          cut;
    logic        trunc;
    logic        end_str;
    logic [7:0]  lead;
    logic [7:0]  cont;
    while (bytes_sent < target) begin
      shape = $urandom_range(0, 9);
      if (shape < 3) shape = SEQ_ASCII;
      else if (shape < 9) shape = SEQ_MULTI;
      else shape = SEQ_STRAY;
      case (shape)
        SEQ_ASCII: send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 7) == 0);
        SEQ_STRAY: send_byte(8'($urandom_range(8'h80, 8'hBF)), $urandom_range(0, 3) == 0);
        default: begin
          n = $urandom_range(2, 4);
          case (n)
            4:       lead = 8'($urandom_range(8'hF0, 8'hFF));
            3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hC0, 8'hDF));
          endcase
          trunc   = ($urandom_range(0, 5) == 0);
          cut     = trunc ? $urandom_range(1, n - 1) : n;
          end_str = trunc || ($urandom_range(0, 3) == 0);
          for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 7) == 0) cont = 8'($urandom);
            else cont = {2'b10, 6'($urandom)};
            send_byte((i == 0) ? lead : cont, end_str && (i == cut - 1));
          end
        end
      endcase
    end
  endtask

  // Arbitrary bytes, broken sequences included.
  task automatic test_noise(input int count);
    repeat (count) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    int waited;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    in_last    = 1'b0;
    errors     = 0;
    bytes_sent = 0;
    cps_checked = 0;
    bad_seen   = 0;
    burst_left = 0;
    clear_sequence();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_sequences(TOTAL_BYTES - NOISE_BYTES);
    test_noise(NOISE_BYTES);

    // Drain the remaining results.
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_cps.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_cps.size() != 0) begin
      errors++;
      $display("%0t: %0d expected code points never arrived", $time, expected_cps.size());
    end

    $display("Sent %0d bytes under random input gaps and output stalls.", bytes_sent);
    $display("Checked %0d code points, %0d of them flagged bad.", cps_checked, bad_seen);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
